// ----- rtl/efe_pkg.sv -----
// Shared types, codes and the CRC step function of the escaped frame encoder.
`default_nettype none
package efe_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PendW = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MaxOut = 3;
  localparam int unsigned CntW = 2;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_END   = 2'd2,
    REQ_SEQRST = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ESCAPE    = 3'd0,
    CFG_DATA0     = 3'd1,
    CFG_DATA1     = 3'd2,
    CFG_END       = 3'd3,
    CFG_PLAIN_XOR = 3'd4
  } cfg_idx_e;

  localparam logic [ByteW-1:0] EscapeReset = 8'hEF;
  localparam logic [ByteW-1:0] Data0Reset  = 8'h44;
  localparam logic [ByteW-1:0] Data1Reset  = 8'h31;
  localparam logic [ByteW-1:0] EndReset    = 8'hF0;

  // Bytes from this value up open an escape run.
  localparam logic [ByteW-1:0] EscOpenMin  = 8'hEF;
  // Bytes up to this value close an open run.
  localparam logic [ByteW-1:0] EscCloseMax = 8'h8F;
  localparam logic [ByteW-1:0] EscOffset   = 8'd16;
  localparam logic [ByteW-1:0] CrcPoly     = 8'h8C;

  // One byte of the reflected CRC-8 (poly 0x31), or a plain xor when selected.
  function automatic logic [ByteW-1:0] crc_step(input logic [ByteW-1:0] crc,
                                                input logic [ByteW-1:0] v,
                                                input logic plain);
    logic [ByteW-1:0] x;
    x = crc ^ v;
    if (!plain) begin
      for (int i = 0; i < ByteW; i++) begin
        x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
      end
    end
    return x;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/escaped_frame_encoder_crc8.sv -----
// Top level of the escaped frame encoder with CRC-8 trailer.
`default_nettype none
// A request is captured in an input register; once the result buffer is empty
// or handing out its last byte, it is encoded against the frame state and its
// output bytes, up to three, load a small result buffer that drains one byte
// per cycle while the output is ready. A new request is taken every cycle
// while the buffer keeps up: start and payload bytes give one output byte, a
// payload byte that flushes a pending character two, an end request up to
// three, and a sequence reset none. Configuration writes are always ready and
// should only be issued while the encoder is idle.
module escaped_frame_encoder_crc8 (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Request stream.
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [efe_pkg::ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  wire  [1:0]                   s_axis_tuser,   // [1:0] req_type
  // Encoded byte stream.
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [efe_pkg::ByteW-1:0]    m_axis_tdata,   // [7:0] out_byte
  output logic                         m_axis_tlast,   // last_of_run
  output logic                         m_axis_tuser,   // [0] frame_end
  // Configuration writes.
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [efe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [efe_pkg::ByteW-1:0]    cfg_data_i
);
  import efe_pkg::*;

  // Configuration registers.
  logic [ByteW-1:0] esc_code_q, d0_code_q, d1_code_q, end_code_q;
  logic             plain_q;

  // Input register.
  logic             in_vld_q;
  req_e             in_req_q;
  logic [ByteW-1:0] in_byte_q;

  // Frame state.
  logic [ByteW-1:0] crc_q, crc_d;
  logic             esc_q, esc_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic             odd_q, odd_d;

  // Result buffer, drained from entry 0.
  logic [ByteW-1:0] obuf_q [MaxOut];
  logic [CntW-1:0]  rem_q;
  logic             end_q;

  logic [ByteW-1:0] res [MaxOut];
  logic [CntW-1:0]  res_n;
  logic             res_end;

  logic             out_fire, advance;

  // Encoding of one byte through the escape path.
  logic [ByteW-1:0] eb, enc_crc, eb_off;
  logic [ByteW-1:0] enc [2];
  logic [CntW-1:0]  enc_n;
  logic             enc_esc;
  logic [PendW-1:0] enc_pend;
  logic [ByteW-1:0] type_code;

  assign cfg_ready_o = 1'b1;

  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign advance       = in_vld_q && ((rem_q == '0) || ((rem_q == CntW'(1)) && out_fire));
  assign s_axis_tready = !in_vld_q || advance;

  assign m_axis_tvalid = (rem_q != '0);
  assign m_axis_tdata  = obuf_q[0];
  assign m_axis_tlast  = (rem_q == CntW'(1));
  assign m_axis_tuser  = end_q && (rem_q == CntW'(1));

  always_comb begin
    eb       = (in_req_q == REQ_END) ? crc_q : in_byte_q;
    eb_off   = eb - EscOffset;
    enc_crc  = crc_step(crc_q, eb, plain_q);
    enc[0]   = eb;
    enc[1]   = eb;
    enc_n    = CntW'(1);
    enc_esc  = esc_q;
    enc_pend = pend_q;
    if (!esc_q) begin
      if (eb >= EscOpenMin) begin
        enc[0]   = esc_code_q;
        enc_pend = eb_off[PendW-1:0];
        enc_esc  = 1'b1;
      end
    end else if (eb <= EscCloseMax) begin
      enc[0]  = {1'b0, pend_q};
      enc[1]  = eb;
      enc_n   = CntW'(2);
      enc_esc = 1'b0;
    end else begin
      // Still escaping: the held character goes out marked, this one waits.
      enc[0]   = {1'b1, pend_q};
      enc_pend = eb_off[PendW-1:0];
    end
  end

  always_comb begin
    type_code = odd_q ? d1_code_q : d0_code_q;
    res[0]    = enc[0];
    res[1]    = enc[1];
    res[2]    = end_code_q;
    res_n     = '0;
    res_end   = 1'b0;
    crc_d     = crc_q;
    esc_d     = esc_q;
    pend_d    = pend_q;
    odd_d     = odd_q;
    unique case (in_req_q)
      REQ_START: begin
        res[0] = type_code;
        res_n  = CntW'(1);
        esc_d  = 1'b0;
        pend_d = '0;
        crc_d  = crc_step('0, type_code, plain_q);
      end
      REQ_DATA: begin
        res_n  = enc_n;
        crc_d  = enc_crc;
        esc_d  = enc_esc;
        pend_d = enc_pend;
      end
      REQ_END: begin
        res_end = 1'b1;
        crc_d   = enc_crc;
        esc_d   = 1'b0;
        pend_d  = enc_pend;
        odd_d   = !odd_q;
        if (enc_esc) begin
          // Flush the held character ahead of the terminator.
          res[1] = {1'b0, enc_pend};
          res_n  = CntW'(3);
        end else if (enc_n == CntW'(2)) begin
          res_n  = CntW'(3);
        end else begin
          res[1] = end_code_q;
          res_n  = CntW'(2);
        end
      end
      REQ_SEQRST: begin
        odd_d = 1'b0;
      end
      default: begin
        res_n = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_code_q <= EscapeReset;
      d0_code_q  <= Data0Reset;
      d1_code_q  <= Data1Reset;
      end_code_q <= EndReset;
      plain_q    <= 1'b0;
      in_vld_q   <= 1'b0;
      in_req_q   <= REQ_START;
      crc_q      <= '0;
      esc_q      <= 1'b0;
      pend_q     <= '0;
      odd_q      <= 1'b0;
      rem_q      <= '0;
      end_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ESCAPE:    esc_code_q <= cfg_data_i;
          CFG_DATA0:     d0_code_q  <= cfg_data_i;
          CFG_DATA1:     d1_code_q  <= cfg_data_i;
          CFG_END:       end_code_q <= cfg_data_i;
          CFG_PLAIN_XOR: plain_q    <= cfg_data_i[0];
          default:       ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        in_vld_q <= 1'b1;
        in_req_q <= req_e'(s_axis_tuser);
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end

      if (advance) begin
        crc_q  <= crc_d;
        esc_q  <= esc_d;
        pend_q <= pend_d;
        odd_q  <= odd_d;
        rem_q  <= res_n;
        end_q  <= res_end;
      end else if (out_fire) begin
        rem_q  <= rem_q - CntW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      for (int i = 0; i < MaxOut; i++) begin
        obuf_q[i] <= res[i];
      end
    end else if (out_fire) begin
      obuf_q[0] <= obuf_q[1];
      obuf_q[1] <= obuf_q[2];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/efe_checker.sv -----
// Port-level checks for the escaped frame encoder, bound to its top level.
`default_nettype none
module efe_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         s_axis_tvalid,
  input wire                         s_axis_tready,
  input wire                         m_axis_tvalid,
  input wire                         m_axis_tready,
  input wire [efe_pkg::ByteW-1:0]    m_axis_tdata,
  input wire                         m_axis_tlast,
  input wire                         m_axis_tuser,
  input wire                         cfg_valid_i,
  input wire                         cfg_ready_o
);
  import efe_pkg::*;

  // The frame terminator is always the final byte of its request.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end byte not marked last");

  // With nothing waiting on the output, a new request can always be taken.
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

  // A stalled output byte holds its value and flags.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled output changed");

endmodule

bind escaped_frame_encoder_crc8 efe_checker u_efe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the escaped frame encoder with CRC-8 trailer.
`default_nettype none
module testbench;
  import efe_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned ItemsPerPhase = 90;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last_of_run;
    logic             frame_end;
  } enc_byte_t;

  // Tracks the frame state of the encoder and the bytes it still owes us.
  class frame_scoreboard;
    logic [ByteW-1:0] escape_code = EscapeReset;
    logic [ByteW-1:0] data0_code  = Data0Reset;
    logic [ByteW-1:0] data1_code  = Data1Reset;
    logic [ByteW-1:0] end_code    = EndReset;
    logic             plain_xor   = 1'b0;

    logic [ByteW-1:0] crc     = '0;
    logic             in_run  = 1'b0;
    logic [PendW-1:0] held    = '0;
    logic             odd_seq = 1'b0;

    enc_byte_t staged[$];
    enc_byte_t owed[$];
    int errors = 0;
    int checked = 0;
    int frames_closed = 0;

    function void set_reg(cfg_idx_e idx, logic [ByteW-1:0] v);
      case (idx)
        CFG_ESCAPE:    escape_code = v;
        CFG_DATA0:     data0_code = v;
        CFG_DATA1:     data1_code = v;
        CFG_END:       end_code = v;
        CFG_PLAIN_XOR: plain_xor = v[0];
        default: ;
      endcase
    endfunction

    // Reflected CRC-8, shifting one bit out per step; plain mode skips the shifts.
    function logic [ByteW-1:0] crc_next(logic [ByteW-1:0] c, logic [ByteW-1:0] v);
      logic [ByteW-1:0] x;
      logic fb;
      x = c ^ v;
      if (!plain_xor) begin
        for (int i = 0; i < ByteW; i++) begin
          fb = x[0];
          x = x >> 1;
          if (fb) x = x ^ CrcPoly;
        end
      end
      return x;
    endfunction

    function void stage(logic [ByteW-1:0] b, logic fe);
      staged.push_back('{out_byte: b, last_of_run: 1'b0, frame_end: fe});
    endfunction

    function void encode(logic [ByteW-1:0] b);
      crc = crc_next(crc, b);
      if (!in_run) begin
        if (b >= EscOpenMin) begin
          stage(escape_code, 1'b0);
          held = PendW'(b - EscOffset);
          in_run = 1'b1;
        end else begin
          stage(b, 1'b0);
        end
      end else if (b <= EscCloseMax) begin
        stage({1'b0, held}, 1'b0);
        stage(b, 1'b0);
        in_run = 1'b0;
      end else begin
        // The run goes on: the held character leaves marked with bit 7.
        stage({1'b1, held}, 1'b0);
        held = PendW'(b - EscOffset);
      end
    endfunction

    function void note_request(req_e r, logic [ByteW-1:0] b);
      logic [ByteW-1:0] t;
      staged.delete();
      case (r)
        REQ_START: begin
          t = odd_seq ? data1_code : data0_code;
          in_run = 1'b0;
          held = '0;
          crc = crc_next('0, t);
          stage(t, 1'b0);
        end
        REQ_DATA: encode(b);
        REQ_END: begin
          encode(crc);
          if (in_run) begin
            stage({1'b0, held}, 1'b0);
            in_run = 1'b0;
          end
          stage(end_code, 1'b1);
          odd_seq = ~odd_seq;
        end
        default: odd_seq = 1'b0;
      endcase
      if (staged.size() > 0) staged[$].last_of_run = 1'b1;
      foreach (staged[i]) owed.push_back(staged[i]);
    endfunction

    function void check_result(logic [ByteW-1:0] ob, logic l, logic fe);
      enc_byte_t want;
      enc_byte_t got;
      got = '{out_byte: ob, last_of_run: l, frame_end: fe};
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte %02h (last %0b, end %0b)", $time, ob, l, fe);
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display({"%0t: mismatch: expected byte %02h last %0b end %0b,",
                  " got byte %02h last %0b end %0b"},
                 $time, want.out_byte, want.last_of_run, want.frame_end, ob, l, fe);
      end else if (fe) begin
        frames_closed++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [ByteW-1:0]    m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [ByteW-1:0]    cfg_data_i;

  frame_scoreboard sb = new();
  int idle_pct = 0;
  int requests_sent = 0;
  int cycles = 0;

  escaped_frame_encoder_crc8 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d bytes outstanding", $time, sb.owed.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if (idle_pct == 0 || $urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Payload bytes weighted toward the escape thresholds.
  function automatic logic [ByteW-1:0] pick_payload();
    case ($urandom_range(9))
      0, 1, 2: return ByteW'($urandom_range(8'hEF, 8'hFF));
      3, 4:    return ByteW'($urandom_range(8'h90, 8'hEE));
      5, 6:    return ByteW'($urandom_range(8'h00, 8'h8F));
      default: return ByteW'($urandom);
    endcase
  endfunction

  task automatic send_req(req_e r, logic [ByteW-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(r, b);
    requests_sent++;
  endtask

  task automatic send_frame();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
    send_req(REQ_START, ByteW'($urandom));
    repeat (n) send_req(REQ_DATA, pick_payload());
    send_req(REQ_END, ByteW'($urandom));
  endtask

  task automatic random_phase(int n_items);
    int first;
    first = requests_sent;
    while (requests_sent - first < n_items) begin
      if ($urandom_range(99) < 15) send_req(req_e'($urandom_range(0, 3)), ByteW'($urandom));
      else send_frame();
    end
  endtask

  // Sender holds off until every owed byte has come out, then lets the pipe drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [ByteW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, v);
  endtask

  task automatic program_regs(logic [ByteW-1:0] esc, logic [ByteW-1:0] d0,
                              logic [ByteW-1:0] d1, logic [ByteW-1:0] endc, logic px);
    cfg_write(CFG_ESCAPE, esc);
    cfg_write(CFG_DATA0, d0);
    cfg_write(CFG_DATA1, d1);
    cfg_write(CFG_END, endc);
    cfg_write(CFG_PLAIN_XOR, {7'd0, px});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic directed();
    // Full frame through every escape transition, end flushing a held character.
    send_req(REQ_START, 8'hFF);
    send_req(REQ_DATA, 8'h00);
    send_req(REQ_DATA, 8'hFF);
    send_req(REQ_DATA, 8'h90);
    send_req(REQ_DATA, 8'h8F);
    send_req(REQ_DATA, 8'hEE);
    send_req(REQ_DATA, 8'hEF);
    send_req(REQ_END, 8'h00);
    // A start in the middle of an open run drops the held character.
    send_req(REQ_START, 8'h5A);
    send_req(REQ_DATA, 8'hF5);
    send_req(REQ_START, 8'hA5);
    send_req(REQ_DATA, 8'h12);
    send_req(REQ_END, 8'hFF);
    // Sequence reset, then an empty frame.
    send_req(REQ_SEQRST, 8'hC3);
    send_req(REQ_START, 8'h3C);
    send_req(REQ_END, 8'h81);
    // Payload and end with no start in front of them.
    send_req(REQ_DATA, 8'h34);
    send_req(REQ_END, 8'h7E);
    // End arriving while a run is still open.
    send_req(REQ_START, 8'h00);
    send_req(REQ_DATA, 8'hFE);
    send_req(REQ_END, 8'h00);
    // Sequence reset in the middle of a frame.
    send_req(REQ_START, 8'h00);
    send_req(REQ_DATA, 8'hF0);
    send_req(REQ_DATA, 8'hFF);
    send_req(REQ_SEQRST, 8'hFF);
    send_req(REQ_DATA, 8'h80);
    send_req(REQ_END, 8'h00);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_START;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_ESCAPE;
    cfg_data_i    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();
    settle();

    program_regs(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    idle_pct = 0;
    random_phase(ItemsPerPhase);
    settle();

    program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    idle_pct = 40;
    random_phase(ItemsPerPhase);
    settle();

    program_regs(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom), ByteW'($urandom), 1'b1);
    idle_pct = 25;
    random_phase(ItemsPerPhase);
    settle();

    program_regs(EscapeReset, Data0Reset, Data1Reset, EndReset, 1'b0);
    idle_pct = 60;
    random_phase(ItemsPerPhase);
    settle();

    if (sb.owed.size() > 0) begin
      sb.errors++;
      $display("%0t: %0d expected bytes never arrived", $time, sb.owed.size());
    end
    $display({"Sent %0d requests over five register settings;",
              " %0d bytes checked, %0d frames closed."},
             requests_sent, sb.checked, sb.frames_closed);
    $display("Both stream sides idled at random, with one long output stall.");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Output side: random back-pressure plus one long hold once traffic is flowing.
  initial begin
    int rx_idle;
    bit held_once;
    rx_idle = 0;
    held_once = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end
      // The long hold starts only while the sender is offering requests.
      if (!held_once && sb.checked >= 300 && s_axis_tvalid) begin
        held_once = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (rx_idle > 0) begin
        m_axis_tready <= 1'b0;
        rx_idle--;
      end else begin
        rx_idle = pick_gap();
        if (rx_idle > 0) begin
          m_axis_tready <= 1'b0;
          rx_idle--;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire
